[design/ebalu_pkg.sv]
// Shared types and constants for the eight-bit CPU ALU with flags.
`default_nettype none

package ebalu_pkg;

  // Operation codes
  typedef enum logic [3:0] {
    OP_ADD        = 4'd0,
    OP_ADC        = 4'd1,
    OP_SUB        = 4'd2,
    OP_SBC        = 4'd3,
    OP_AND        = 4'd4,
    OP_XOR        = 4'd5,
    OP_OR         = 4'd6,
    OP_CP         = 4'd7,
    OP_INC8       = 4'd8,
    OP_DEC8       = 4'd9,
    OP_CPL        = 4'd10,
    OP_DAA        = 4'd11,
    OP_ADD16      = 4'd12,
    OP_INC16      = 4'd13,
    OP_DEC16      = 4'd14,
    OP_ADD_OFFSET = 4'd15
  } alu_kind_e;

  // Decimal adjust limits
  localparam logic [7:0] DaaByteLimit   = 8'h99;
  localparam logic [3:0] DaaNibbleLimit = 4'h9;

  // One operation request
  typedef struct packed {
    alu_kind_e   kind;
    logic [15:0] first_operand;
    logic [15:0] second_operand;
    logic        zero_in;
    logic        subtract_in;
    logic        half_carry_in;
    logic        carry_in;
  } alu_req_t;

  // One operation result
  typedef struct packed {
    logic [15:0] result_value;
    logic        writes_back;
    logic        zero_out;
    logic        subtract_out;
    logic        half_carry_out;
    logic        carry_out;
  } alu_rsp_t;

endpackage

`default_nettype wire

[design/eight_bit_cpu_alu_with_flags_top.sv]
// Top level: input register, ALU datapath and result register with valid/stall handshake.
//
//   channel  direction  handshake                      payload
//   in       input      in_valid_i / in_stall_o        in_data_i   (ebalu_pkg::alu_req_t)
//   out      output     out_valid_o / out_stall_i      out_data_o  (ebalu_pkg::alu_rsp_t)
//
// Each transaction passes through the input register, then through the ALU into the
// result register.
// One transaction is accepted per cycle while the output is taken.
// in_stall_o rises only when both registers hold a transaction and the output is stalled.
// Reset empties both registers; there is no other state.
`default_nettype none

module eight_bit_cpu_alu_with_flags_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  ebalu_pkg::alu_req_t in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ebalu_pkg::alu_rsp_t out_data_o
);

  logic                s1_valid_q;
  logic                s1_valid_d;
  ebalu_pkg::alu_req_t s1_data_q;
  logic                out_valid_q;
  logic                out_valid_d;
  ebalu_pkg::alu_rsp_t out_data_q;
  ebalu_pkg::alu_rsp_t alu_rsp;
  logic                s1_adv;
  logic                s2_adv;

  // Advance a stage when it is empty or the next one moves
  assign s2_adv     = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;

  assign s1_valid_d  = s1_adv ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_adv ? s1_valid_q : out_valid_q;

  // Hold valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture payloads when their stage advances
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_data_q <= in_data_i;
    end
    if (s2_adv) begin
      out_data_q <= alu_rsp;
    end
  end

  ebalu_core u_core (
    .req_i (s1_data_q),
    .rsp_o (alu_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // Stall upstream only when both registers are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free register");

  // An accepted transaction lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted transaction lost");

  // A held input transaction is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_data_q)))
    else $error("held transaction dropped or changed");

  // A compare yields a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.writes_back) |-> (out_data_o.result_value == 16'd0))
    else $error("compare result not zero");
`endif

endmodule

`default_nettype wire

[design/ebalu_core.sv]
// Combinational datapath: result value and new flags for one operation.
`default_nettype none

module ebalu_core (
  input  ebalu_pkg::alu_req_t req_i,
  output ebalu_pkg::alu_rsp_t rsp_o
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] x;
  logic [15:0] y;
  logic        cin;
  logic        bin;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  diff9;
  logic [4:0]  hdiff5;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_corr;
  logic [7:0]  daa_val;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [15:0] off16;
  logic [15:0] offs_sum;
  logic [4:0]  offs_h5;
  logic [8:0]  offs_c9;
  logic [7:0]  logic8;

  assign x = req_i.first_operand;
  assign y = req_i.second_operand;
  assign a = x[7:0];
  assign b = y[7:0];

  // Add and subtract with carry or borrow
  assign cin    = (req_i.kind == ebalu_pkg::OP_ADC) & req_i.carry_in;
  assign bin    = (req_i.kind == ebalu_pkg::OP_SBC) & req_i.carry_in;
  assign sum9   = {1'b0, a} + {1'b0, b} + {8'b0, cin};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
  assign diff9  = {1'b0, a} - {1'b0, b} - {8'b0, bin};
  assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, bin};

  // Increment and decrement
  assign inc8 = a + 8'd1;
  assign dec8 = a - 8'd1;

  // Decimal adjust: one correction constant, added or subtracted
  assign daa_hi   = req_i.subtract_in ? req_i.carry_in
                                      : (req_i.carry_in | (a > ebalu_pkg::DaaByteLimit));
  assign daa_lo   = req_i.subtract_in ? req_i.half_carry_in
                                      : (req_i.half_carry_in
                                         | (a[3:0] > ebalu_pkg::DaaNibbleLimit));
  assign daa_corr = {1'b0, daa_hi, daa_hi, 1'b0, 1'b0, daa_lo, daa_lo, 1'b0};
  assign daa_val  = req_i.subtract_in ? (a - daa_corr) : (a + daa_corr);

  // 16-bit add
  assign sum17  = {1'b0, x} + {1'b0, y};
  assign hsum13 = {1'b0, x[11:0]} + {1'b0, y[11:0]};

  // Signed byte offset add
  assign off16    = {{8{b[7]}}, b};
  assign offs_sum = x + off16;
  assign offs_h5  = {1'b0, x[3:0]} + {1'b0, b[3:0]};
  assign offs_c9  = {1'b0, x[7:0]} + {1'b0, b};

  // Select result and flags per operation
  always_comb begin
    rsp_o.result_value   = 16'd0;
    rsp_o.writes_back    = 1'b1;
    rsp_o.zero_out       = req_i.zero_in;
    rsp_o.subtract_out   = req_i.subtract_in;
    rsp_o.half_carry_out = req_i.half_carry_in;
    rsp_o.carry_out      = req_i.carry_in;
    logic8               = a & b;
    unique case (req_i.kind)
      ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
        rsp_o.result_value   = {8'd0, sum9[7:0]};
        rsp_o.zero_out       = (sum9[7:0] == 8'd0);
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = hsum5[4];
        rsp_o.carry_out      = sum9[8];
      end
      ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP: begin
        rsp_o.result_value   = {8'd0, diff9[7:0]};
        rsp_o.zero_out       = (diff9[7:0] == 8'd0);
        rsp_o.subtract_out   = 1'b1;
        rsp_o.half_carry_out = hdiff5[4];
        rsp_o.carry_out      = diff9[8];
        if (req_i.kind == ebalu_pkg::OP_CP) begin
          rsp_o.result_value = 16'd0;
          rsp_o.writes_back  = 1'b0;
        end
      end
      ebalu_pkg::OP_AND, ebalu_pkg::OP_XOR, ebalu_pkg::OP_OR: begin
        if (req_i.kind == ebalu_pkg::OP_XOR) begin
          logic8 = a ^ b;
        end else if (req_i.kind == ebalu_pkg::OP_OR) begin
          logic8 = a | b;
        end
        rsp_o.result_value   = {8'd0, logic8};
        rsp_o.zero_out       = (logic8 == 8'd0);
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = (req_i.kind == ebalu_pkg::OP_AND);
        rsp_o.carry_out      = 1'b0;
      end
      ebalu_pkg::OP_INC8: begin
        rsp_o.result_value   = {8'd0, inc8};
        rsp_o.zero_out       = (inc8 == 8'd0);
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = (inc8[3:0] == 4'h0);
      end
      ebalu_pkg::OP_DEC8: begin
        rsp_o.result_value   = {8'd0, dec8};
        rsp_o.zero_out       = (dec8 == 8'd0);
        rsp_o.subtract_out   = 1'b1;
        rsp_o.half_carry_out = (dec8[3:0] == 4'hF);
      end
      ebalu_pkg::OP_CPL: begin
        rsp_o.result_value   = {8'd0, ~a};
        rsp_o.subtract_out   = 1'b1;
        rsp_o.half_carry_out = 1'b1;
      end
      ebalu_pkg::OP_DAA: begin
        rsp_o.result_value   = {8'd0, daa_val};
        rsp_o.zero_out       = (daa_val == 8'd0);
        rsp_o.half_carry_out = 1'b0;
        rsp_o.carry_out      = req_i.subtract_in ? req_i.carry_in : daa_hi;
      end
      ebalu_pkg::OP_ADD16: begin
        rsp_o.result_value   = sum17[15:0];
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = hsum13[12];
        rsp_o.carry_out      = sum17[16];
      end
      ebalu_pkg::OP_INC16: begin
        rsp_o.result_value = x + 16'd1;
      end
      ebalu_pkg::OP_DEC16: begin
        rsp_o.result_value = x - 16'd1;
      end
      ebalu_pkg::OP_ADD_OFFSET: begin
        rsp_o.result_value   = offs_sum;
        rsp_o.zero_out       = 1'b0;
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = offs_h5[4];
        rsp_o.carry_out      = offs_c9[8];
      end
    endcase
  end

endmodule

`default_nettype wire

[tb/alu_flags_checker.sv]
// Checker for the ALU: predicts each accepted operation and compares its result in order.
module alu_flags_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ebalu_pkg::alu_req_t in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ebalu_pkg::alu_rsp_t out_data_i,
  output int unsigned         error_count_o,
  output int unsigned         pending_o
);
  import ebalu_pkg::*;

  // Keep the log readable when the block is badly broken
  localparam int unsigned PrintLimit = 50;

  alu_rsp_t expected_results[$];

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (error_count_o < PrintLimit) begin
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
    error_count_o = error_count_o + 1;
  endtask

  // Compute the value and flags one operation produces
  function automatic alu_rsp_t predict_alu_result(input alu_req_t req);
    alu_rsp_t    rsp;
    logic [7:0]  acc;
    logic [7:0]  opnd;
    logic [7:0]  adj;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic [15:0] offset;
    logic        cin;
    acc  = req.first_operand[7:0];
    opnd = req.second_operand[7:0];
    // Flags pass through unless the operation touches them
    rsp.result_value   = 16'h0000;
    rsp.writes_back    = 1'b1;
    rsp.zero_out       = req.zero_in;
    rsp.subtract_out   = req.subtract_in;
    rsp.half_carry_out = req.half_carry_in;
    rsp.carry_out      = req.carry_in;
    case (req.kind)
      OP_ADD, OP_ADC: begin
        cin  = (req.kind == OP_ADC) ? req.carry_in : 1'b0;
        sum9 = {1'b0, acc} + {1'b0, opnd} + {8'h00, cin};
        nib5 = {1'b0, acc[3:0]} + {1'b0, opnd[3:0]} + {4'h0, cin};
        rsp.result_value   = {8'h00, sum9[7:0]};
        rsp.zero_out       = (sum9[7:0] == 8'h00);
        rsp.subtract_out   = 1'b0;
        rsp.half_carry_out = nib5[4];
        rsp.carry_out      = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // Bit 8 and bit 4 of the differences are the borrows
        cin  = (req.kind == OP_SBC) ? req.carry_in : 1'b0;
        sum9 = {1'b0, acc} - {1'b0, opnd} - {8'h00, cin};
        nib5 = {1'b0, acc[3:0]} - {1'b0, opnd[3:0]} - {4'h0, cin};
        rsp.result_value   = {8'h00, sum9[7:0]};
        rsp.zero_out       = (sum9[7:0] == 8'h00);
        rsp.subtract_out   = 1'b1;
        rsp.half_carry_out = nib5[4];
        rsp.carry_out      = sum9[8];
        // Compare drops the value and the writeback
        if (req.kind == OP_CP) begin
          rsp.result_value = 16'h0000;
          rsp.writes_back  = 1'b0;
        end
      end
      OP_AND: begin
        rsp.result_value   = {8'h00, acc & opnd};
        rsp.zero_out       = ((acc & opnd) == 8'h00);
        rsp.subtract_out   = 1'b0;
        rsp.half_carry_out = 1'b1;
        rsp.carry_out      = 1'b0;
      end
      OP_XOR, OP_OR: begin
        adj = (req.kind == OP_XOR) ? (acc ^ opnd) : (acc | opnd);
        rsp.result_value   = {8'h00, adj};
        rsp.zero_out       = (adj == 8'h00);
        rsp.subtract_out   = 1'b0;
        rsp.half_carry_out = 1'b0;
        rsp.carry_out      = 1'b0;
      end
      OP_INC8: begin
        adj = acc + 8'h01;
        rsp.result_value   = {8'h00, adj};
        rsp.zero_out       = (adj == 8'h00);
        rsp.subtract_out   = 1'b0;
        rsp.half_carry_out = (adj[3:0] == 4'h0);
      end
      OP_DEC8: begin
        adj = acc - 8'h01;
        rsp.result_value   = {8'h00, adj};
        rsp.zero_out       = (adj == 8'h00);
        rsp.subtract_out   = 1'b1;
        rsp.half_carry_out = (adj[3:0] == 4'hF);
      end
      OP_CPL: begin
        rsp.result_value   = {8'h00, ~acc};
        rsp.subtract_out   = 1'b1;
        rsp.half_carry_out = 1'b1;
      end
      OP_DAA: begin
        adj = acc;
        if (!req.subtract_in) begin
          // After an addition: fix the high digit first, then the low one
          if (req.carry_in || (adj > DaaByteLimit)) begin
            adj           = adj + 8'h60;
            rsp.carry_out = 1'b1;
          end
          if (req.half_carry_in || (adj[3:0] > DaaNibbleLimit)) begin
            adj = adj + 8'h06;
          end
        end else begin
          // After a subtraction: only the incoming borrows matter
          if (req.carry_in) begin
            adj = adj - 8'h60;
          end
          if (req.half_carry_in) begin
            adj = adj - 8'h06;
          end
        end
        rsp.result_value   = {8'h00, adj};
        rsp.zero_out       = (adj == 8'h00);
        rsp.half_carry_out = 1'b0;
      end
      OP_ADD16: begin
        sum17 = {1'b0, req.first_operand} + {1'b0, req.second_operand};
        sum13 = {1'b0, req.first_operand[11:0]} + {1'b0, req.second_operand[11:0]};
        rsp.result_value   = sum17[15:0];
        rsp.subtract_out   = 1'b0;
        rsp.half_carry_out = sum13[12];
        rsp.carry_out      = sum17[16];
      end
      OP_INC16: begin
        rsp.result_value = req.first_operand + 16'h0001;
      end
      OP_DEC16: begin
        rsp.result_value = req.first_operand - 16'h0001;
      end
      OP_ADD_OFFSET: begin
        // Value uses the signed byte; flags come from the unsigned low-byte add
        offset = {{8{opnd[7]}}, opnd};
        sum9   = {1'b0, req.first_operand[7:0]} + {1'b0, opnd};
        nib5   = {1'b0, req.first_operand[3:0]} + {1'b0, opnd[3:0]};
        rsp.result_value   = req.first_operand + offset;
        rsp.zero_out       = 1'b0;
        rsp.subtract_out   = 1'b0;
        rsp.half_carry_out = nib5[4];
        rsp.carry_out      = sum9[8];
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // Check the result transaction first, then queue the new operation
  always @(posedge clk_i) begin : watch_channels
    alu_rsp_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no pending operation", out_data_i.result_value,
                          16'h0000);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.result_value !== want.result_value) begin
            report_mismatch("result_value", out_data_i.result_value, want.result_value);
          end
          if (out_data_i.writes_back !== want.writes_back) begin
            report_mismatch("writes_back", {15'h0, out_data_i.writes_back},
                            {15'h0, want.writes_back});
          end
          if (out_data_i.zero_out !== want.zero_out) begin
            report_mismatch("zero_out", {15'h0, out_data_i.zero_out}, {15'h0, want.zero_out});
          end
          if (out_data_i.subtract_out !== want.subtract_out) begin
            report_mismatch("subtract_out", {15'h0, out_data_i.subtract_out},
                            {15'h0, want.subtract_out});
          end
          if (out_data_i.half_carry_out !== want.half_carry_out) begin
            report_mismatch("half_carry_out", {15'h0, out_data_i.half_carry_out},
                            {15'h0, want.half_carry_out});
          end
          if (out_data_i.carry_out !== want.carry_out) begin
            report_mismatch("carry_out", {15'h0, out_data_i.carry_out},
                            {15'h0, want.carry_out});
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(predict_alu_result(in_data_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top: drives ALU operations with random idling on both sides and gives the verdict.
module tb;
  import ebalu_pkg::*;

  localparam int unsigned RandomOps = 1725;
  localparam int unsigned QuietFrom = 1500;

  logic        clk;
  logic        rst_n;
  logic        req_valid;
  logic        req_stall;
  alu_req_t    req_data;
  logic        rsp_valid;
  logic        rsp_stall;
  alu_rsp_t    rsp_data;
  int unsigned error_count;
  int unsigned pending_ops;
  logic        tail_quiet;
  logic        gap_mode;

  eight_bit_cpu_alu_with_flags_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_data_o  (rsp_data)
  );

  alu_flags_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_stall_i    (req_stall),
    .in_data_i     (req_data),
    .out_valid_i   (rsp_valid),
    .out_stall_i   (rsp_stall),
    .out_data_i    (rsp_data),
    .error_count_o (error_count),
    .pending_o     (pending_ops)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #6000000;
    $display("[eight_bit_cpu_alu_with_flags_top] ERROR");
    $finish;
  end

  // Stall the result side in random bursts, with long calm stretches
  initial begin : result_stall
    int unsigned stall_left;
    int unsigned free_left;
    stall_left = 0;
    free_left  = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (tail_quiet) begin
        rsp_stall <= 1'b0;
      end else begin
        if (stall_left == 0 && free_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: stall_left = $urandom_range(1, 13);
            4:          free_left  = $urandom_range(100, 300);
            default:    free_left  = $urandom_range(1, 20);
          endcase
        end
        if (stall_left != 0) begin
          rsp_stall <= 1'b1;
          stall_left = stall_left - 1;
        end else begin
          rsp_stall <= 1'b0;
          free_left = free_left - 1;
        end
      end
    end
  end

  // Send one operation, after an optional idle burst; return at its acceptance edge
  task automatic push_op(input alu_kind_e kind, input logic [15:0] first,
                         input logic [15:0] second, input logic [3:0] znhc);
    alu_req_t req;
    req.kind           = kind;
    req.first_operand  = first;
    req.second_operand = second;
    req.zero_in        = znhc[3];
    req.subtract_in    = znhc[2];
    req.half_carry_in  = znhc[1];
    req.carry_in       = znhc[0];
    if (!tail_quiet && gap_mode && $urandom_range(0, 2) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= req;
    do @(posedge clk); while (req_stall);
  endtask

  // Mix corner values with uniform ones
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'h00FF;
      2:       return 16'h000F;
      3:       return 16'h0099;
      4:       return 16'h0080;
      5:       return 16'hFFFF;
      6:       return 16'h0FFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned n;
    rst_n      <= 1'b0;
    req_valid  <= 1'b0;
    req_data   <= '0;
    tail_quiet <= 1'b0;
    gap_mode   <= 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: carries, borrows, zero results, ignored upper bytes, kept flags
    push_op(OP_ADD,        16'h000F, 16'h0001, 4'b0000);
    push_op(OP_ADD,        16'hAB01, 16'hCDFF, 4'b0000);
    push_op(OP_ADC,        16'h00FF, 16'h0000, 4'b0001);
    push_op(OP_SUB,        16'h0010, 16'h0001, 4'b0000);
    push_op(OP_SBC,        16'h0000, 16'hFFFF, 4'b0001);
    push_op(OP_AND,        16'h12F0, 16'h340F, 4'b1111);
    push_op(OP_XOR,        16'h00FF, 16'hFFFF, 4'b0000);
    push_op(OP_OR,         16'hFFA5, 16'h005A, 4'b1111);
    push_op(OP_CP,         16'h0042, 16'hFF42, 4'b0000);
    push_op(OP_CP,         16'h0000, 16'h0001, 4'b1111);
    push_op(OP_INC8,       16'h00FF, 16'h0000, 4'b0001);
    push_op(OP_INC8,       16'hFF0F, 16'h0000, 4'b1110);
    push_op(OP_DEC8,       16'h0000, 16'hFFFF, 4'b0000);
    push_op(OP_DEC8,       16'h0001, 16'h0000, 4'b0001);
    push_op(OP_CPL,        16'h805A, 16'h0000, 4'b1001);
    push_op(OP_DAA,        16'h009A, 16'h0000, 4'b0000);
    push_op(OP_DAA,        16'h0045, 16'h0000, 4'b0011);
    push_op(OP_DAA,        16'h0000, 16'h0000, 4'b0111);
    push_op(OP_ADD16,      16'h0FFF, 16'h0001, 4'b0000);
    push_op(OP_ADD16,      16'hFFFF, 16'h0001, 4'b1000);
    push_op(OP_INC16,      16'hFFFF, 16'h1234, 4'b1111);
    push_op(OP_DEC16,      16'h0000, 16'hFFFF, 4'b1010);
    push_op(OP_ADD_OFFSET, 16'h0000, 16'hABFF, 4'b1111);
    push_op(OP_ADD_OFFSET, 16'hFFF8, 16'h0008, 4'b0000);
    push_op(OP_ADD_OFFSET, 16'h1234, 16'h0080, 4'b0101);

    // Random operations; sender idling switches on and off in stretches
    for (n = 0; n < RandomOps; n++) begin
      if (n % 64 == 0) begin
        gap_mode <= ($urandom_range(0, 3) != 0);
      end
      if (n == QuietFrom) begin
        tail_quiet <= 1'b1;
      end
      push_op(alu_kind_e'($urandom_range(0, 15)), pick_operand(), pick_operand(),
              4'($urandom_range(0, 15)));
    end
    req_valid <= 1'b0;

    // Drain, then allow the pipeline latency to settle
    while (pending_ops != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0 && pending_ops == 0) begin
      $display("[eight_bit_cpu_alu_with_flags_top] OK");
    end else begin
      $display("[eight_bit_cpu_alu_with_flags_top] ERROR");
    end
    $finish;
  end

endmodule
